/* hw/rtl/lsq_pkg.sv */
// Shared types and constants for the Latin square completion counter.
// Used by lsq_ctrl, lsq_datapath and latin_square_exact_cover_solver.
`default_nettype none
package lsq_pkg;
   localparam int VAL_W = 4;
   localparam int CNT_W = 32;
   localparam int REQ_W = 16;
   localparam int RSP_W = 40;

   localparam logic ACT_FIX   = 1'b0;
   localparam logic ACT_COUNT = 1'b1;

   typedef struct packed {
      logic load;
      logic fix;
      logic start;
      logic fwd;
      logic back;
      logic undo;
   } lsq_cmd_type;

   typedef struct packed {
      logic at_end;
      logic at_start;
      logic cur_fixed;
      logic found;
   } lsq_stat_type;
endpackage
`default_nettype wire

/* hw/rtl/lsq_datapath.sv */
// Grid, used-symbol masks, search cursor and saturating counter.
// Driven by lsq_ctrl commands; depends on lsq_pkg.
`default_nettype none
module lsq_datapath import lsq_pkg::*; #(
   parameter int WIDTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lsq_cmd_type       cmd,
   input  wire logic [REQ_W-1:0]  req_data,
   output lsq_stat_type           stat,
   output logic                   accepted,
   output logic [CNT_W-1:0]       solution_count
);
   localparam int RW = $clog2(WIDTH);

   logic [VAL_W-1:0] grid_ff [WIDTH][WIDTH];
   logic [WIDTH-1:0] fixb_ff [WIDTH];
   logic [WIDTH-1:0] rowu_ff [WIDTH];
   logic [WIDTH-1:0] colu_ff [WIDTH];
   logic [RW-1:0]    r_ff, c_ff;
   logic             end_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             acc_ff;
   logic [2:0]       in_row_ff, in_col_ff;
   logic [VAL_W-1:0] in_val_ff;

   logic [VAL_W-1:0] cur_val, cur_dec, in_dec;
   logic             cur_fix, found, fix_ok, in_range;
   logic [WIDTH-1:0] cand;
   logic [RW-1:0]    new_idx, fr, fc, fv, cv;

   always_comb begin
      cur_val = grid_ff[r_ff][c_ff];
      cur_fix = fixb_ff[r_ff][c_ff];
      cur_dec = cur_val - VAL_W'(1);
      cv      = cur_dec[RW-1:0];
      new_idx = '0;
      for (int i = 0; i < WIDTH; i++) begin
         cand[i] = !rowu_ff[r_ff][i] && !colu_ff[c_ff][i] && (VAL_W'(i) >= cur_val);
      end
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (cand[i]) begin
            new_idx = RW'(i);
         end
      end
      found = |cand;
      in_dec = in_val_ff - VAL_W'(1);
      fr = in_row_ff[RW-1:0];
      fc = in_col_ff[RW-1:0];
      fv = in_dec[RW-1:0];
      in_range = ({1'b0, in_row_ff} < 4'(WIDTH)) && ({1'b0, in_col_ff} < 4'(WIDTH)) &&
                 (in_val_ff != '0) && (in_val_ff <= VAL_W'(WIDTH));
      fix_ok = in_range && !fixb_ff[fr][fc] && !rowu_ff[fr][fv] && !colu_ff[fc][fv];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIDTH; i++) begin
            for (int j = 0; j < WIDTH; j++) begin
               grid_ff[i][j] <= '0;
            end
            fixb_ff[i] <= '0;
            rowu_ff[i] <= '0;
            colu_ff[i] <= '0;
         end
         end_ff <= 1'b0;
         r_ff   <= '0;
         c_ff   <= '0;
      end else begin
         if (cmd.load) begin
            in_row_ff <= req_data[3:1];
            in_col_ff <= req_data[6:4];
            in_val_ff <= req_data[10:7];
         end
         if (cmd.fix) begin
            acc_ff <= fix_ok;
            cnt_ff <= '0;
            if (fix_ok) begin
               grid_ff[fr][fc] <= in_val_ff;
               fixb_ff[fr][fc] <= 1'b1;
               rowu_ff[fr][fv] <= 1'b1;
               colu_ff[fc][fv] <= 1'b1;
            end
         end
         if (cmd.start) begin
            r_ff   <= '0;
            c_ff   <= '0;
            end_ff <= 1'b0;
            cnt_ff <= '0;
            acc_ff <= 1'b1;
         end
         if (cmd.fwd) begin
            if (end_ff) begin
               if (cnt_ff != '1) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end else if (cur_fix || found) begin
               if (!cur_fix) begin
                  grid_ff[r_ff][c_ff]    <= VAL_W'(new_idx) + VAL_W'(1);
                  rowu_ff[r_ff][new_idx] <= 1'b1;
                  colu_ff[c_ff][new_idx] <= 1'b1;
               end
               if (c_ff == RW'(WIDTH - 1)) begin
                  if (r_ff == RW'(WIDTH - 1)) begin
                     end_ff <= 1'b1;
                  end else begin
                     r_ff <= r_ff + RW'(1);
                     c_ff <= '0;
                  end
               end else begin
                  c_ff <= c_ff + RW'(1);
               end
            end else begin
               grid_ff[r_ff][c_ff] <= '0;
            end
         end
         if (cmd.back) begin
            if (end_ff) begin
               end_ff <= 1'b0;
            end else if (c_ff == '0) begin
               c_ff <= RW'(WIDTH - 1);
               r_ff <= r_ff - RW'(1);
            end else begin
               c_ff <= c_ff - RW'(1);
            end
         end
         if (cmd.undo && !cur_fix) begin
            rowu_ff[r_ff][cv] <= 1'b0;
            colu_ff[c_ff][cv] <= 1'b0;
         end
      end
   end

   assign stat.at_end    = end_ff;
   assign stat.at_start  = !end_ff && (r_ff == '0) && (c_ff == '0);
   assign stat.cur_fixed = cur_fix;
   assign stat.found     = found;
   assign accepted       = acc_ff;
   assign solution_count = cnt_ff;
endmodule
`default_nettype wire

/* hw/rtl/lsq_ctrl.sv */
// Sequencer for fix requests and the backtracking search.
// Issues lsq_datapath commands; depends on lsq_pkg.
`default_nettype none
module lsq_ctrl import lsq_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_action,
   input  wire logic         rsp_tready,
   input  wire lsq_stat_type stat,
   output lsq_cmd_type       cmd,
   output logic              req_tready,
   output logic              rsp_tvalid
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_FIX, ST_START, ST_TRY, ST_BACK, ST_UNDO, ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, valid_ff;

   always_comb begin
      cmd.load  = (state_ff == ST_IDLE) && req_tvalid;
      cmd.fix   = (state_ff == ST_FIX);
      cmd.start = (state_ff == ST_START);
      cmd.fwd   = (state_ff == ST_TRY);
      cmd.back  = (state_ff == ST_BACK) && !stat.at_start;
      cmd.undo  = (state_ff == ST_UNDO);
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_action == ACT_FIX) ? ST_FIX : ST_START;
            end
         end
         ST_FIX:   state_in = ST_RESP;
         ST_START: state_in = ST_TRY;
         ST_TRY: begin
            if (stat.at_end || (!stat.cur_fixed && !stat.found)) begin
               state_in = ST_BACK;
            end
         end
         ST_BACK:  state_in = stat.at_start ? ST_RESP : ST_UNDO;
         ST_UNDO:  state_in = stat.cur_fixed ? ST_BACK : ST_TRY;
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
         valid_ff <= (state_in == ST_RESP);
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = valid_ff;
endmodule
`default_nettype wire

/* hw/rtl/latin_square_exact_cover_solver.sv */
// A fix request passes through the fix state and then raises its response.
// A count request starts the search, takes forward cell steps and
// backtrack steps (back, undo, retry), then raises its response.
// One request at a time; the next is accepted from the cycle after the response is taken.
// Synchronous reset clears the grid and used-symbol masks.
`default_nettype none
module latin_square_exact_cover_solver import lsq_pkg::*; #(
   parameter int WIDTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_W-1:0]  req_tdata,  // action, cell_row, cell_column, cell_value
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata   // accepted, solution_count
);
   lsq_cmd_type      cmd;
   lsq_stat_type     stat;
   logic             accepted;
   logic [CNT_W-1:0] solution_count;

   lsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tdata[0]),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid)
   );

   lsq_datapath #(.WIDTH(WIDTH)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_data       (req_tdata),
      .stat           (stat),
      .accepted       (accepted),
      .solution_count (solution_count)
   );

   assign rsp_tdata = {(RSP_W - CNT_W - 1)'(0), solution_count, accepted};

`ifndef SYNTH
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready while response pending");
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[32:1] == '0))
      else $error("rejected fix with nonzero count");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("second request taken");
`endif
endmodule
`default_nettype wire
